// ===== rtl/core/req_pkg.sv =====
// Shared types and constants for the retry event queue.
// Depends on nothing; imported by retry_event_queue and tb_retry_event_queue.
`default_nettype none

package req_pkg;

    localparam int QueueDepthDef = 32;
    localparam int BatchMaxDef   = 8;

    // add reply status codes
    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_INVAL = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_BATCH = 1'b1;

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_SRV_HI   = 3'd0;
    localparam logic [2:0] CFG_SRV_LO   = 3'd1;
    localparam logic [2:0] CFG_RUN_MARK = 3'd2;
    localparam logic [2:0] CFG_RETRY_IV = 3'd3;
    localparam logic [2:0] CFG_LIMIT    = 3'd4;

    localparam logic [7:0] BYTE_EMPTY = 8'h00;
    localparam logic [7:0] BYTE_ALL   = 8'hff;

    // one slot record as held in the slot memory
    typedef struct packed {
        logic [15:0] dest;
        logic [63:0] body;
        logic [7:0]  timer;
        logic [4:0]  tries;
        logic        direct;
    } rec_t;

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ARD  = 9'b000000010,
        S_AEX  = 9'b000000100,
        S_AFIN = 9'b000001000,
        S_TRD  = 9'b000010000,
        S_TEX  = 9'b000100000,
        S_BRD  = 9'b001000000,
        S_BEX  = 9'b010000000,
        S_BEND = 9'b100000000
    } state_t;

    // saturating increment of the pending count
    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        logic [7:0] r;
        r = (v == 8'hff) ? v : v + 8'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/retry_event_queue.sv =====
// Retry event queue: slot table with timers, retry counts and send batches.
// Depends on req_pkg.
//
// An invalid add answers in the cycle after it is taken, and a tick with
// nothing pending gives no result and leaves the block idle; other commands
// walk the slot memory slot by slot, first reading each slot and then acting
// on it. One command at a time; busy is high meanwhile. Results are strobed
// one cycle each and cannot be stalled. Reset clears all valid bits at once.
`default_nettype none

module retry_event_queue #(
    parameter int QUEUE_DEPTH = req_pkg::QueueDepthDef,
    parameter int BATCH_MAX   = req_pkg::BatchMaxDef
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cmd,
    input  wire logic [7:0]  dest_high,
    input  wire logic [7:0]  dest_low,
    input  wire logic [63:0] event_body,
    input  wire logic        direct_route,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             result_valid,
    output logic             kind,
    output logic [1:0]       status,
    output logic [4:0]       slot,
    output logic [7:0]       target_high,
    output logic [7:0]       target_low,
    output logic [7:0]       out_dest_high,
    output logic [7:0]       out_dest_low,
    output logic [63:0]      out_body,
    output logic             last
);
    import req_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(BATCH_MAX + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] N_LAST   = NW'(BATCH_MAX - 1);

    // configuration registers
    logic [7:0] srv_hi_reg, srv_lo_reg, run_mark_reg, retry_iv_reg;
    logic [3:0] limit_reg;

    // sequencer and command state
    state_t              state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [15:0]         in_dest_reg, in_dest_next;
    logic [63:0]         in_body_reg, in_body_next;
    logic                in_direct_reg, in_direct_next;
    logic                free_found_reg, free_found_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;
    logic [7:0]          pend_reg, pend_next;
    logic [15:0]         hdest_reg, hdest_next;
    logic                hdirect_reg, hdirect_next;
    logic [15:0]         tgt_reg, tgt_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                held_valid_reg, held_valid_next;
    logic [4:0]          held_slot_reg, held_slot_next;
    logic [15:0]         held_dest_reg, held_dest_next;
    logic [63:0]         held_body_reg, held_body_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;

    // result registers
    logic        o_valid_reg, o_valid_next;
    logic        o_kind_reg, o_kind_next;
    logic [1:0]  o_status_reg, o_status_next;
    logic [4:0]  o_slot_reg, o_slot_next;
    logic [15:0] o_tgt_reg, o_tgt_next;
    logic [15:0] o_dest_reg, o_dest_next;
    logic [63:0] o_body_reg, o_body_next;
    logic        o_last_reg, o_last_next;

    // slot memory, one port each way
    rec_t          mem [QUEUE_DEPTH];
    rec_t          rd_q;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    rec_t          mem_wd;

    logic [IW+7:0] idx_ext, free_ext;
    logic [4:0]    idx_slot, free_slot;
    logic          cur_valid;
    logic [4:0]    tries_inc;
    logic          accept;
    logic [7:0]    in_b2;

    assign idx_ext   = {8'd0, idx_reg};
    assign free_ext  = {8'd0, free_idx_reg};
    assign idx_slot  = idx_ext[4:0];
    assign free_slot = free_ext[4:0];
    assign cur_valid = valid_reg[idx_reg];
    assign tries_inc = (rd_q.tries == 5'd31) ? rd_q.tries : rd_q.tries + 5'd1;
    assign accept    = start && (state_reg == S_IDLE);
    assign in_b2     = event_body[63:56];

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_valid  = o_valid_reg;
    assign kind          = o_kind_reg;
    assign status        = o_status_reg;
    assign slot          = o_slot_reg;
    assign target_high   = o_tgt_reg[15:8];
    assign target_low    = o_tgt_reg[7:0];
    assign out_dest_high = o_dest_reg[15:8];
    assign out_dest_low  = o_dest_reg[7:0];
    assign out_body      = o_body_reg;
    assign last          = o_last_reg;

    // read the slot at the walk index, write the record chosen by the sequencer
    always_ff @(posedge clk)
    begin
        rd_q <= mem[idx_reg];
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srv_hi_reg   <= 8'd0;
            srv_lo_reg   <= 8'd150;
            run_mark_reg <= 8'd50;
            retry_iv_reg <= 8'd60;
            limit_reg    <= 4'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SRV_HI:   srv_hi_reg   <= cfg_data;
                CFG_SRV_LO:   srv_lo_reg   <= cfg_data;
                CFG_RUN_MARK: run_mark_reg <= cfg_data;
                CFG_RETRY_IV: retry_iv_reg <= cfg_data;
                CFG_LIMIT:    limit_reg    <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        in_dest_next    = in_dest_reg;
        in_body_next    = in_body_reg;
        in_direct_next  = in_direct_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_next       = pend_reg;
        hdest_next      = hdest_reg;
        hdirect_next    = hdirect_reg;
        tgt_next        = tgt_reg;
        n_next          = n_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        held_dest_next  = held_dest_reg;
        held_body_next  = held_body_reg;
        valid_next      = valid_reg;
        o_valid_next    = 1'b0;
        o_kind_next     = KIND_REPLY;
        o_status_next   = ST_ADDED;
        o_slot_next     = 5'd0;
        o_tgt_next      = 16'd0;
        o_dest_next     = 16'd0;
        o_body_next     = 64'd0;
        o_last_next     = 1'b1;
        mem_we          = 1'b0;
        mem_wa          = idx_reg;
        mem_wd          = rd_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    in_dest_next    = {dest_high, dest_low};
                    in_body_next    = event_body;
                    in_direct_next  = direct_route;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    if (cmd == CMD_ADD)
                    begin
                        if (in_b2 == BYTE_EMPTY || in_b2 == BYTE_ALL)
                        begin
                            o_valid_next  = 1'b1;
                            o_status_next = ST_INVAL;
                        end
                        else
                        begin
                            state_next = S_ARD;
                        end
                    end
                    else if (pend_reg != 8'd0)
                    begin
                        pend_next  = 8'd0;
                        state_next = S_TRD;
                    end
                end
            end

            S_ARD:  state_next = S_AEX;

            // look for a duplicate, note the first free slot
            S_AEX:
            begin
                if (cur_valid && rd_q.dest == in_dest_reg && rd_q.body == in_body_reg)
                begin
                    if (rd_q.timer < run_mark_reg)
                    begin
                        mem_we          = 1'b1;
                        mem_wd.timer    = run_mark_reg - 8'd1;
                    end
                    pend_next     = sat_inc8(pend_reg);
                    o_valid_next  = 1'b1;
                    o_status_next = ST_DUP;
                    o_slot_next   = idx_slot;
                    state_next    = S_IDLE;
                end
                else
                begin
                    if (!cur_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_AFIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_ARD;
                    end
                end
            end

            // store into the free slot or report full
            S_AFIN:
            begin
                o_valid_next = 1'b1;
                if (free_found_reg)
                begin
                    mem_we                  = 1'b1;
                    mem_wa                  = free_idx_reg;
                    mem_wd.dest             = in_dest_reg;
                    mem_wd.body             = in_body_reg;
                    mem_wd.timer            = run_mark_reg;
                    mem_wd.tries            = 5'd0;
                    mem_wd.direct           = in_direct_reg;
                    valid_next[free_idx_reg] = 1'b1;
                    pend_next               = sat_inc8(pend_reg);
                    o_status_next           = ST_ADDED;
                    o_slot_next             = free_slot;
                end
                else
                begin
                    o_status_next = ST_FULL;
                end
                state_next = S_IDLE;
            end

            S_TRD:  state_next = S_TEX;

            // age timers and free spent slots until a head is found
            S_TEX:
            begin
                if (cur_valid)
                begin
                    pend_next = sat_inc8(pend_reg);
                end
                if (cur_valid && rd_q.timer == run_mark_reg)
                begin
                    if (tries_inc > {1'b0, limit_reg})
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        mem_wd.tries   = tries_inc;
                        hdest_next     = rd_q.dest;
                        hdirect_next   = rd_q.direct;
                        tgt_next       = rd_q.direct ? rd_q.dest : {srv_hi_reg, srv_lo_reg};
                    end
                end
                else if (cur_valid && rd_q.timer != 8'd0)
                begin
                    mem_we       = 1'b1;
                    mem_wd.timer = rd_q.timer - 8'd1;
                end
                else if (cur_valid)
                begin
                    valid_next[idx_reg] = 1'b0;
                end

                if (cur_valid && rd_q.timer == run_mark_reg && !(tries_inc > {1'b0, limit_reg}))
                begin
                    idx_next        = '0;
                    n_next          = '0;
                    held_valid_next = 1'b0;
                    state_next      = S_BRD;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TRD;
                end
            end

            S_BRD:  state_next = S_BEX;

            // collect batch entries, hold one back to mark the last
            S_BEX:
            begin
                if (cur_valid && rd_q.timer == run_mark_reg
                    && (!hdirect_reg || rd_q.dest == hdest_reg))
                begin
                    mem_we       = 1'b1;
                    mem_wd.timer = retry_iv_reg;
                    if (held_valid_reg)
                    begin
                        o_valid_next = 1'b1;
                        o_kind_next  = KIND_BATCH;
                        o_slot_next  = held_slot_reg;
                        o_tgt_next   = tgt_reg;
                        o_dest_next  = held_dest_reg;
                        o_body_next  = held_body_reg;
                        o_last_next  = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_slot_next  = idx_slot;
                    held_dest_next  = rd_q.dest;
                    held_body_next  = rd_q.body;
                    n_next          = n_reg + 1'b1;
                    if (n_reg == N_LAST || idx_reg == IDX_LAST)
                    begin
                        state_next = S_BEND;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_BRD;
                    end
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = S_BEND;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_BRD;
                end
            end

            // flush the held entry as the last one
            S_BEND:
            begin
                o_valid_next    = held_valid_reg;
                o_kind_next     = KIND_BATCH;
                o_slot_next     = held_slot_reg;
                o_tgt_next      = tgt_reg;
                o_dest_next     = held_dest_reg;
                o_body_next     = held_body_reg;
                o_last_next     = 1'b1;
                held_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            pend_reg       <= 8'd0;
            n_reg          <= '0;
            held_valid_reg <= 1'b0;
            valid_reg      <= '0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            pend_reg       <= pend_next;
            n_reg          <= n_next;
            held_valid_reg <= held_valid_next;
            valid_reg      <= valid_next;
            o_valid_reg    <= o_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_dest_reg   <= in_dest_next;
        in_body_reg   <= in_body_next;
        in_direct_reg <= in_direct_next;
        free_idx_reg  <= free_idx_next;
        hdest_reg     <= hdest_next;
        hdirect_reg   <= hdirect_next;
        tgt_reg       <= tgt_next;
        held_slot_reg <= held_slot_next;
        held_dest_reg <= held_dest_next;
        held_body_reg <= held_body_next;
        o_kind_reg    <= o_kind_next;
        o_status_reg  <= o_status_next;
        o_slot_reg    <= o_slot_next;
        o_tgt_reg     <= o_tgt_next;
        o_dest_reg    <= o_dest_next;
        o_body_reg    <= o_body_next;
        o_last_reg    <= o_last_next;
    end

endmodule

`default_nettype wire

// ===== bench/tb_retry_event_queue.sv =====
// Self-checking bench for the retry event queue: directed and random commands,
// checked against a behavioral model of the slot table kept inside the bench.
// Depends on req_pkg and retry_event_queue.
`timescale 1ns / 100ps

module tb_retry_event_queue;
    import req_pkg::*;

    localparam int DEPTH    = 32;
    localparam int BATCH    = 8;
    localparam int SETTLE   = 4 * DEPTH + 12;

    // one expected result word
    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [7:0]  th;
        logic [7:0]  tl;
        logic [7:0]  dh;
        logic [7:0]  dl;
        logic [63:0] body;
        logic        last;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [7:0]  dest_high;
    logic [7:0]  dest_low;
    logic [63:0] event_body;
    logic        direct_route;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        result_valid;
    logic        kind;
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [7:0]  target_high;
    logic [7:0]  target_low;
    logic [7:0]  out_dest_high;
    logic [7:0]  out_dest_low;
    logic [63:0] out_body;
    logic        last;

    // shadow copy of the slot table and registers
    logic [15:0] tab_dest [DEPTH];
    logic [63:0] tab_body [DEPTH];
    logic [7:0]  tab_timer [DEPTH];
    logic [4:0]  tab_tries [DEPTH];
    logic        tab_direct [DEPTH];
    logic [7:0]  pend_cnt;
    logic [7:0]  srv_hi, srv_lo, run_mark, retry_iv;
    logic [3:0]  retry_lim;

    word_t       words_due[$];
    int          errors;
    int          idle_pct;
    logic [15:0] dest_pool [4];
    logic [63:0] body_pool [4];

    retry_event_queue i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .dest_high(dest_high), .dest_low(dest_low), .event_body(event_body),
        .direct_route(direct_route), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
        .kind(kind), .status(status), .slot(slot), .target_high(target_high),
        .target_low(target_low), .out_dest_high(out_dest_high),
        .out_dest_low(out_dest_low), .out_body(out_body), .last(last)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #5ms;
        $display("** retry_event_queue: FAILED **");
        $finish;
    end

    function automatic void free_slot(int i);
        tab_dest[i]   = '0;
        tab_body[i]   = '0;
        tab_timer[i]  = '0;
        tab_tries[i]  = '0;
        tab_direct[i] = 1'b0;
    endfunction

    function automatic bit in_use(int i);
        return tab_body[i][63:56] != BYTE_EMPTY;
    endfunction

    function automatic void raise_pending();
        if (pend_cnt != 8'hff)
            pend_cnt = pend_cnt + 8'd1;
    endfunction

    function automatic void push_reply(logic [1:0] st, logic [4:0] idx);
        word_t w;
        w = '{KIND_REPLY, st, idx, 8'd0, 8'd0, 8'd0, 8'd0, 64'd0, 1'b1};
        words_due.push_back(w);
    endfunction

    // apply one add command to the shadow table
    function automatic void model_add(logic [15:0] d, logic [63:0] b, logic dr);
        if (b[63:56] == BYTE_EMPTY || b[63:56] == BYTE_ALL)
        begin
            push_reply(ST_INVAL, 5'd0);
            return;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (in_use(i) && tab_dest[i] == d && tab_body[i] == b)
            begin
                if (tab_timer[i] < run_mark)
                    tab_timer[i] = run_mark - 8'd1;
                raise_pending();
                push_reply(ST_DUP, 5'(i));
                return;
            end
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!in_use(i))
            begin
                tab_dest[i]   = d;
                tab_body[i]   = b;
                tab_timer[i]  = run_mark;
                tab_tries[i]  = '0;
                tab_direct[i] = dr;
                raise_pending();
                push_reply(ST_ADDED, 5'(i));
                return;
            end
        end
        push_reply(ST_FULL, 5'd0);
    endfunction

    // apply one tick: age timers, find the head, build the send batch
    function automatic void model_tick();
        bit          found;
        int          head;
        int          n;
        logic [7:0]  th, tl;
        word_t       w;
        found = 0;
        head  = 0;
        n     = 0;
        if (pend_cnt == 8'd0)
            return;
        pend_cnt = 8'd0;
        for (int i = 0; i < DEPTH && !found; i++)
        begin
            if (!in_use(i))
                continue;
            raise_pending();
            if (tab_timer[i] == run_mark)
            begin
                if (tab_tries[i] < 5'd31)
                    tab_tries[i] = tab_tries[i] + 5'd1;
                if (tab_tries[i] > {1'b0, retry_lim})
                    free_slot(i);
                else
                begin
                    head  = i;
                    found = 1;
                end
            end
            else if (tab_timer[i] > 8'd0)
                tab_timer[i] = tab_timer[i] - 8'd1;
            else
                free_slot(i);
        end
        if (!found)
            return;
        th = tab_direct[head] ? tab_dest[head][15:8] : srv_hi;
        tl = tab_direct[head] ? tab_dest[head][7:0] : srv_lo;
        for (int m = 0; m < DEPTH && n < BATCH; m++)
        begin
            if (!in_use(m) || tab_timer[m] != run_mark)
                continue;
            if (tab_direct[head] && tab_dest[m] != tab_dest[head])
                continue;
            tab_timer[m] = retry_iv;
            w = '{KIND_BATCH, ST_ADDED, 5'(m), th, tl, tab_dest[m][15:8],
                  tab_dest[m][7:0], tab_body[m], 1'b0};
            words_due.push_back(w);
            n++;
        end
        words_due[words_due.size() - 1].last = 1'b1;
    endfunction

    // hold start low while random draws fall under idle_pct
    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // offer one command word and wait until the block takes it
    task automatic send_word(logic c, logic [15:0] d, logic [63:0] b, logic dr);
        sender_gap();
        start        <= 1'b1;
        cmd          <= c;
        dest_high    <= d[15:8];
        dest_low     <= d[7:0];
        event_body   <= b;
        direct_route <= dr;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (c == CMD_ADD)
            model_add(d, b, dr);
        else
            model_tick();
    endtask

    task automatic send_tick();
        send_word(CMD_TICK, 16'($urandom), {$urandom, $urandom}, 1'($urandom));
    endtask

    // hold off until all results are in and the block has settled
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SRV_HI:   srv_hi    = val;
            CFG_SRV_LO:   srv_lo    = val;
            CFG_RUN_MARK: run_mark  = val;
            CFG_RETRY_IV: retry_iv  = val;
            CFG_LIMIT:    retry_lim = val[3:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [7:0] hi, logic [7:0] lo, logic [7:0] rm,
                             logic [7:0] iv, logic [3:0] lim);
        drain();
        write_reg(CFG_SRV_HI, hi);
        write_reg(CFG_SRV_LO, lo);
        write_reg(CFG_RUN_MARK, rm);
        write_reg(CFG_RETRY_IV, iv);
        write_reg(CFG_LIMIT, {4'd0, lim});
        @(posedge clk);
    endtask

    // body with a usable byte 2 and random other bytes
    function automatic logic [63:0] good_body();
        logic [63:0] b;
        b = {$urandom, $urandom};
        b[63:56] = 8'($urandom_range(1, 254));
        return b;
    endfunction

    // invalid bodies, duplicates, shared destinations, a send and retries
    task automatic test_add_and_send();
        send_tick();
        send_word(CMD_ADD, 16'h1234, 64'h00ff_ffff_ffff_ffff, 1'b1);
        send_word(CMD_ADD, 16'h1234, 64'hff00_0000_0000_0000, 1'b0);
        send_word(CMD_ADD, 16'hffff, 64'h01ff_ffff_ffff_ffff, 1'b0);
        send_word(CMD_ADD, 16'hffff, 64'h01ff_ffff_ffff_ffff, 1'b1);
        send_word(CMD_ADD, 16'h0000, 64'hfe00_0000_0000_0000, 1'b1);
        send_word(CMD_ADD, 16'h0000, 64'h7f5a_a5a5_5a5a_a5a5, 1'b1);
        send_word(CMD_ADD, 16'h00ff, 64'h80a5_5a5a_a5a5_5a5a, 1'b0);
        send_tick();
        send_tick();
        send_word(CMD_ADD, 16'hffff, 64'h01ff_ffff_ffff_ffff, 1'b0);
        send_tick();
        write_all(8'hff, 8'hff, 8'd1, 8'd2, 4'd0);
        send_word(CMD_ADD, 16'ha5a5, 64'h1111_2222_3333_4444, 1'b0);
        repeat (6) send_tick();
        write_all(8'h00, 8'h00, 8'd2, 8'd3, 4'd1);
        send_word(CMD_ADD, 16'h5a5a, 64'h2222_3333_4444_5555, 1'b1);
        repeat (6) send_tick();
    endtask

    // fill every slot, then one more add is refused
    task automatic test_full_table();
        write_all(8'h3c, 8'hc3, 8'd254, 8'd255, 4'd15);
        for (int i = 0; i <= DEPTH; i++)
            send_word(CMD_ADD, 16'(i), good_body(), 1'($urandom));
        repeat (4) send_tick();
        // pause until every result is back
        drain();
        send_word(CMD_ADD, dest_pool[0], body_pool[0], 1'b1);
    endtask

    // random commands with mostly repeated events to reach duplicates and batches
    task automatic test_random(int count);
        int          pick;
        logic [63:0] b;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_tick();
            else
            begin
                b = body_pool[$urandom_range(3)];
                if (pick < 48)
                    b[63:56] = $urandom_range(1) ? BYTE_ALL : BYTE_EMPTY;
                else if (pick < 58)
                    b = {$urandom, $urandom};
                send_word(CMD_ADD, dest_pool[$urandom_range(3)], b, 1'($urandom));
            end
        end
    endtask

    // compare each result word with the oldest expected one
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && result_valid === 1'b1)
        begin
            if (words_due.size() == 0)
            begin
                $error("unexpected result word, slot %0d", slot);
                errors++;
            end
            else
            begin
                w = words_due.pop_front();
                if (kind !== w.kind)
                begin
                    $error("kind: expected %0h, got %0h", w.kind, kind);
                    errors++;
                end
                if (status !== w.status)
                begin
                    $error("status: expected %0h, got %0h", w.status, status);
                    errors++;
                end
                if (slot !== w.slot)
                begin
                    $error("slot: expected %0d, got %0d", w.slot, slot);
                    errors++;
                end
                if (target_high !== w.th)
                begin
                    $error("target_high: expected %0h, got %0h", w.th, target_high);
                    errors++;
                end
                if (target_low !== w.tl)
                begin
                    $error("target_low: expected %0h, got %0h", w.tl, target_low);
                    errors++;
                end
                if (out_dest_high !== w.dh)
                begin
                    $error("out_dest_high: expected %0h, got %0h", w.dh, out_dest_high);
                    errors++;
                end
                if (out_dest_low !== w.dl)
                begin
                    $error("out_dest_low: expected %0h, got %0h", w.dl, out_dest_low);
                    errors++;
                end
                if (out_body !== w.body)
                begin
                    $error("out_body: expected %0h, got %0h", w.body, out_body);
                    errors++;
                end
                if (last !== w.last)
                begin
                    $error("last: expected %0h, got %0h", w.last, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors       = 0;
        idle_pct     = 35;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_ADD;
        dest_high    = '0;
        dest_low     = '0;
        event_body   = '0;
        direct_route = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_SRV_HI;
        cfg_data     = '0;
        srv_hi       = 8'd0;
        srv_lo       = 8'd150;
        run_mark     = 8'd50;
        retry_iv     = 8'd60;
        retry_lim    = 4'd5;
        pend_cnt     = 8'd0;
        for (int i = 0; i < DEPTH; i++)
            free_slot(i);
        for (int i = 0; i < 4; i++)
        begin
            dest_pool[i] = 16'($urandom);
            body_pool[i] = good_body();
        end
        dest_pool[1] = dest_pool[0];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_and_send();
        test_full_table();
        write_all(8'($urandom), 8'($urandom), 8'($urandom_range(1, 5)),
                  8'($urandom_range(0, 8)), 4'($urandom_range(0, 15)));
        test_random(20);
        idle_pct = 82;
        write_all(8'($urandom), 8'($urandom), 8'($urandom_range(1, 4)),
                  8'($urandom_range(0, 6)), 4'($urandom_range(0, 3)));
        test_random(20);
        idle_pct = 0;
        write_all(8'($urandom), 8'($urandom), 8'($urandom_range(1, 254)),
                  8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        test_random(20);

        drain();
        if (errors == 0 && words_due.size() == 0)
            $display("** retry_event_queue: PASSED **");
        else
            $display("** retry_event_queue: FAILED **");
        $finish;
    end

endmodule
